/* sv/mqrf_pkg.sv */
`default_nettype none

package mqrf_pkg;

  // Fixed field widths of the stream payload
  localparam int DATA_W      = 32;
  localparam int OPCODE_W    = 2;
  localparam int QIDX_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;
  localparam int DROP_W      = 32;

  localparam int IN_TUSER_W  = OPCODE_W + QIDX_W;
  localparam int IN_TDATA_W  = DATA_W;
  localparam int OUT_TUSER_W = STATUS_W;
  localparam int OUT_FIELD_W = DATA_W + FILL_W + DROP_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Operation codes carried in the input item
  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_POP   = 2'd1,
    OP_PUSH  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADIDX = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Control decisions from the queue update logic
  typedef struct packed {
    logic    meta_we;
    logic    entry_we;
    logic    entry_re;
    status_t status;
  } upd_ctrl_t;

endpackage

`default_nettype wire

/* sv/multi_queue_ring_fifo_top.sv */
`default_nettype none

// Bank of NUM_QUEUES circular FIFOs of QUEUE_DEPTH 32-bit words each, driven by
// clear/pop/push items on a stream input; every item yields one result with a
// status, the popped word, and the queue's fill level and dropped-word count.
// The words live in one synchronous RAM and the per-queue pointers, count and
// drop counter in a second one. An item passes through these steps in order:
// the metadata RAM read, the read-modify-write of metadata together with the
// word RAM access, and the load of the output register. The next item is
// accepted while a result waits in the output register; a stalled output
// holds the following item in its last step. Metadata entries read as zero
// until first written after reset, so no clearing pass is needed.
module multi_queue_ring_fifo_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_QUEUES  = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: [31:0] write_data
  input  wire logic [mqrf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: [1:0] opcode, [4:2] queue_index
  input  wire logic [mqrf_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // out_tdata: [31:0] read_data, [36:32] fill_level, [68:37] dropped_count,
  // [71:69] zero
  output logic [mqrf_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // out_tuser: [1:0] status
  output logic [mqrf_pkg::OUT_TUSER_W-1:0]          out_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int META_W = mqrf_pkg::DROP_W + CNT_W + 2 * PTR_W;
  localparam int PAD_W  = mqrf_pkg::OUT_TDATA_W - mqrf_pkg::OUT_FIELD_W;

  // Input field decode
  mqrf_pkg::opcode_t in_op;
  logic [QW-1:0]     in_q;
  logic              in_bad;
  logic              in_acc;

  assign in_op  = mqrf_pkg::opcode_t'(in_tuser[mqrf_pkg::OPCODE_W-1:0]);
  assign in_q   = QW'(in_tuser[mqrf_pkg::IN_TUSER_W-1:mqrf_pkg::OPCODE_W]);
  assign in_bad = (32'(in_tuser[mqrf_pkg::IN_TUSER_W-1:mqrf_pkg::OPCODE_W])
                   >= 32'(NUM_QUEUES));
  assign in_acc = in_tvalid && in_tready;

  // Sequencer and item registers
  mqrf_pkg::state_t state_r, state_nxt;
  mqrf_pkg::opcode_t op_r;
  logic [QW-1:0]     q_r;
  logic              bad_r;
  logic [mqrf_pkg::DATA_W-1:0] wdata_r;

  // Metadata RAM: {drop, count, write ptr, read ptr} per queue
  logic [META_W-1:0] meta_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] meta_vld_r;
  logic [META_W-1:0] meta_rdata_r;
  logic              meta_rvld_r;
  logic [QW-1:0]     meta_raddr;
  logic [META_W-1:0] meta_cur;
  logic [META_W-1:0] meta_wdata;
  logic              meta_we;

  // Word RAM
  logic [mqrf_pkg::DATA_W-1:0] entry_mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [mqrf_pkg::DATA_W-1:0] entry_rdata_r;
  logic [ADDR_W-1:0] entry_addr;
  logic [PTR_W-1:0]  entry_ptr;
  logic              entry_we;
  logic              entry_re;

  // Update logic signals
  logic [PTR_W-1:0]  rp_cur, wp_cur, rp_new, wp_new;
  logic [CNT_W-1:0]  cnt_cur, cnt_new;
  logic [mqrf_pkg::DROP_W-1:0] drop_cur, drop_new;
  mqrf_pkg::upd_ctrl_t ctrl;

  // Pending result fields
  mqrf_pkg::status_t res_status_r;
  logic [mqrf_pkg::FILL_W-1:0] res_fill_r;
  logic [mqrf_pkg::DROP_W-1:0] res_drop_r;
  logic              res_pop_r;

  // Output register
  logic              out_tvalid_r;
  mqrf_pkg::status_t out_status_r;
  logic [mqrf_pkg::DATA_W-1:0] out_rdata_r;
  logic [mqrf_pkg::FILL_W-1:0] out_fill_r;
  logic [mqrf_pkg::DROP_W-1:0] out_drop_r;
  logic              out_free;
  logic              out_load;
  logic              exec_en;

  assign out_free = !out_tvalid_r || out_tready;

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    exec_en   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      mqrf_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = mqrf_pkg::S_EXEC;
        end
      end
      mqrf_pkg::S_EXEC: begin
        exec_en   = 1'b1;
        state_nxt = mqrf_pkg::S_DONE;
      end
      mqrf_pkg::S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = mqrf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mqrf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mqrf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_op;
      q_r     <= in_bad ? '0 : in_q;
      bad_r   <= in_bad;
      wdata_r <= in_tdata[mqrf_pkg::DATA_W-1:0];
    end
  end

  // Metadata RAM read on accept, write back in execute
  assign meta_raddr = in_bad ? '0 : in_q;
  assign meta_we    = exec_en && ctrl.meta_we;
  assign meta_wdata = {drop_new, cnt_new, wp_new, rp_new};

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[q_r] <= meta_wdata;
    end
    if (in_acc) begin
      meta_rdata_r <= meta_mem[meta_raddr];
    end
  end

  // Valid bits stand in for the zero reset of the metadata
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r  <= '0;
      meta_rvld_r <= 1'b0;
    end else begin
      if (meta_we) begin
        meta_vld_r[q_r] <= 1'b1;
      end
      if (in_acc) begin
        meta_rvld_r <= meta_vld_r[meta_raddr];
      end
    end
  end

  assign meta_cur = meta_rvld_r ? meta_rdata_r : '0;
  assign rp_cur   = meta_cur[PTR_W-1:0];
  assign wp_cur   = meta_cur[2*PTR_W-1:PTR_W];
  assign cnt_cur  = meta_cur[2*PTR_W+CNT_W-1:2*PTR_W];
  assign drop_cur = meta_cur[META_W-1:2*PTR_W+CNT_W];

  mqrf_update #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_update (
    .op      (op_r),
    .bad     (bad_r),
    .rp_cur  (rp_cur),
    .wp_cur  (wp_cur),
    .cnt_cur (cnt_cur),
    .drop_cur(drop_cur),
    .rp_new  (rp_new),
    .wp_new  (wp_new),
    .cnt_new (cnt_new),
    .drop_new(drop_new),
    .ctrl    (ctrl)
  );

  // Word RAM access: queue base plus pointer
  assign entry_ptr  = ctrl.entry_we ? wp_cur : rp_cur;
  assign entry_addr = ADDR_W'(q_r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(entry_ptr);
  assign entry_we   = exec_en && ctrl.entry_we;
  assign entry_re   = exec_en && ctrl.entry_re;

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_addr] <= wdata_r;
    end
    if (entry_re) begin
      entry_rdata_r <= entry_mem[entry_addr];
    end
  end

  // Hold the result fields until the popped word arrives
  always_ff @(posedge clk) begin
    if (exec_en) begin
      res_status_r <= ctrl.status;
      res_fill_r   <= bad_r ? '0 : mqrf_pkg::FILL_W'(cnt_new);
      res_drop_r   <= bad_r ? '0 : drop_new;
      res_pop_r    <= ctrl.entry_re;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_rdata_r  <= res_pop_r ? entry_rdata_r : '0;
      out_fill_r   <= res_fill_r;
      out_drop_r   <= res_drop_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_drop_r, out_fill_r, out_rdata_r};

endmodule

`default_nettype wire

/* sv/mqrf_update.sv */
`default_nettype none

// Per-queue update: decides the new pointers, count and drop counter for
// one operation and which memory accesses it needs.
module mqrf_update #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire mqrf_pkg::opcode_t                op,
  input  wire logic                             bad,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   rp_cur,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0]   wp_cur,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_cur,
  input  wire logic [mqrf_pkg::DROP_W-1:0]      drop_cur,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   rp_new,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   wp_new,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_new,
  output logic [mqrf_pkg::DROP_W-1:0]      drop_new,
  output mqrf_pkg::upd_ctrl_t            ctrl
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] rp_adv;
  logic [PTR_W-1:0] wp_adv;

  // Pointers wrap after the last entry
  assign rp_adv = (rp_cur == PTR_LAST) ? '0 : rp_cur + PTR_W'(1);
  assign wp_adv = (wp_cur == PTR_LAST) ? '0 : wp_cur + PTR_W'(1);

  always_comb begin
    rp_new        = rp_cur;
    wp_new        = wp_cur;
    cnt_new       = cnt_cur;
    drop_new      = drop_cur;
    ctrl.meta_we  = 1'b0;
    ctrl.entry_we = 1'b0;
    ctrl.entry_re = 1'b0;
    ctrl.status   = mqrf_pkg::STAT_OK;
    if (bad) begin
      ctrl.status = mqrf_pkg::STAT_BADIDX;
    end else begin
      unique case (op)
        mqrf_pkg::OP_CLEAR: begin
          // drop counter survives a clear
          rp_new       = '0;
          wp_new       = '0;
          cnt_new      = '0;
          ctrl.meta_we = 1'b1;
        end
        mqrf_pkg::OP_POP: begin
          if (cnt_cur == '0) begin
            ctrl.status = mqrf_pkg::STAT_EMPTY;
          end else begin
            rp_new        = rp_adv;
            cnt_new       = cnt_cur - CNT_W'(1);
            ctrl.meta_we  = 1'b1;
            ctrl.entry_re = 1'b1;
          end
        end
        mqrf_pkg::OP_PUSH: begin
          if (cnt_cur >= CNT_FULL) begin
            drop_new     = drop_cur + mqrf_pkg::DROP_W'(1);
            ctrl.meta_we = 1'b1;
            ctrl.status  = mqrf_pkg::STAT_FULL;
          end else begin
            wp_new        = wp_adv;
            cnt_new       = cnt_cur + CNT_W'(1);
            ctrl.meta_we  = 1'b1;
            ctrl.entry_we = 1'b1;
          end
        end
        mqrf_pkg::OP_RSVD: begin
          // no state change, report the queue as it stands
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/mqrf_checker.sv */
`default_nettype none

// Port-level checks of the queue bank
module mqrf_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic [mqrf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [mqrf_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [mqrf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [mqrf_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);

  localparam int RD_HI   = mqrf_pkg::DATA_W - 1;
  localparam int FILL_LO = mqrf_pkg::DATA_W;
  localparam int FILL_HI = mqrf_pkg::DATA_W + mqrf_pkg::FILL_W - 1;
  localparam logic [mqrf_pkg::FILL_W-1:0] FILL_FULL = mqrf_pkg::FILL_W'(QUEUE_DEPTH);

  logic unused_in;
  assign unused_in = ^in_tdata ^ ^in_tuser;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in work");

  // Bad index reports all-zero fields
  a_badidx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mqrf_pkg::STAT_BADIDX) |-> (out_tdata == '0))
    else $error("bad index result carries data");

  // Empty pop reports zero word and zero fill
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mqrf_pkg::STAT_EMPTY)
    |-> (out_tdata[RD_HI:0] == '0) && (out_tdata[FILL_HI:FILL_LO] == '0))
    else $error("empty pop with data or nonzero fill");

  // A dropped push reports a full queue
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == mqrf_pkg::STAT_FULL)
    |-> (out_tdata[FILL_HI:FILL_LO] == FILL_FULL) && (out_tdata[RD_HI:0] == '0))
    else $error("full status without a full queue");

endmodule

bind multi_queue_ring_fifo_top mqrf_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_mqrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);

`default_nettype wire
